// ----- src/nnu_pkg.sv -----
// Package for the nearest-neighbor upscaler: field widths, register indexes,
// the phase type and the job record passed from the front end to the back end.
// No dependencies.
package nnu_pkg;

  localparam int PIX_W      = 24;
  localparam int COLOR_W    = 8;
  localparam int SCALE_W    = 7;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 16;
  localparam int COPY_W     = 6;
  localparam int PAD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Largest replication factor; larger register values are clamped to it.
  localparam int MAX_SCALE = 64;

  // Entries in the queue between front end and back end.
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT = 2'd2;

  typedef enum logic {
    PH_CAPTURE,
    PH_REPLAY
  } phase_t;

  // Effective (clamped) configuration values.
  typedef struct packed {
    logic [SCALE_W-1:0]  scale;
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
  } cfg_t;

  // One classified item: a pixel to be sent out scale times.
  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
    logic [SCALE_W-1:0] scale;
    logic               end_col;
    logic [PAD_W-1:0]   pad;
    logic               fend;
  } job_t;

endpackage

// ----- src/nearest_neighbor_upscaler_core.sv -----
// Nearest-neighbor integer upscaler, top level. An accepted item passes
// through the front-end job register, the job queue and the output register.
// The back end sends scale beats per item, one beat per cycle while not stalled.
// Reset (rst_n low, synchronous) clears phase, positions, queue and output
// valid and sets scale, in_width and in_height to 1; the line store is not cleared.
// Depends on nnu_pkg, nnu_ram, nnu_front, nnu_queue and nnu_back.
module nearest_neighbor_upscaler_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [nnu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nnu_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_command,
  input  logic [nnu_pkg::COLOR_W-1:0]    in_blue,
  input  logic [nnu_pkg::COLOR_W-1:0]    in_green,
  input  logic [nnu_pkg::COLOR_W-1:0]    in_red,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [nnu_pkg::COLOR_W-1:0]    out_blue,
  output logic [nnu_pkg::COLOR_W-1:0]    out_green,
  output logic [nnu_pkg::COLOR_W-1:0]    out_red,
  output logic                           out_last,
  output logic                           out_row_end,
  output logic [nnu_pkg::PAD_W-1:0]      out_pad_bytes,
  output logic                           out_frame_end
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // Raw configuration registers, written as software gives them.
  logic [nnu_pkg::SCALE_W-1:0]  scale_r;
  logic [nnu_pkg::WIDTH_W-1:0]  in_width_r;
  logic [nnu_pkg::HEIGHT_W-1:0] in_height_r;
  nnu_pkg::cfg_t                cfg_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r     <= 7'd1;
      in_width_r  <= 11'd1;
      in_height_r <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nnu_pkg::REG_SCALE:     scale_r     <= cfg_data[nnu_pkg::SCALE_W-1:0];
        nnu_pkg::REG_IN_WIDTH:  in_width_r  <= cfg_data[nnu_pkg::WIDTH_W-1:0];
        nnu_pkg::REG_IN_HEIGHT: in_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective values: zero acts as one, and scale and width are clamped to
  // their maximums.
  always_comb begin
    if (scale_r == '0) begin
      cfg_eff.scale = 7'd1;
    end else if (32'(scale_r) > nnu_pkg::MAX_SCALE) begin
      cfg_eff.scale = 7'(nnu_pkg::MAX_SCALE);
    end else begin
      cfg_eff.scale = scale_r;
    end
    if (in_width_r == '0) begin
      cfg_eff.width = 11'd1;
    end else if (32'(in_width_r) > MAX_WIDTH) begin
      cfg_eff.width = 11'(MAX_WIDTH);
    end else begin
      cfg_eff.width = in_width_r;
    end
    cfg_eff.height = (in_height_r == '0) ? 16'd1 : in_height_r;
  end

  logic                        ram_we, ram_re;
  logic [CW-1:0]               ram_waddr, ram_raddr;
  logic [nnu_pkg::PIX_W-1:0]   ram_wdata, ram_rdata;
  logic                        job_valid, job_ready;
  nnu_pkg::job_t               job, q_head;
  logic                        q_valid, q_pop;

  // Line store holding the current input row for replay.
  nnu_ram #(
    .WIDTH (nnu_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  // Front end: classifies beats, tracks position, builds jobs.
  nnu_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_eff),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_blue    (in_blue),
    .in_green   (in_green),
    .in_red     (in_red),
    .in_stall   (in_stall),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .job_valid  (job_valid),
    .job        (job),
    .job_ready  (job_ready)
  );

  // Queue decoupling the two halves.
  nnu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_valid && job_ready),
    .push_job (job),
    .ready    (job_ready),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  // Back end: replicates each job onto the output channel.
  nnu_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_job         (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_blue      (out_blue),
    .out_green     (out_green),
    .out_red       (out_red),
    .out_last      (out_last),
    .out_row_end   (out_row_end),
    .out_pad_bytes (out_pad_bytes),
    .out_frame_end (out_frame_end)
  );

endmodule

// ----- src/nnu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nnu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

// ----- src/nnu_front.sv -----
// Front end of the upscaler: accepts items, drops those of the wrong kind,
// keeps column, copy and row position, drives the line store and builds jobs.
// Depends on nnu_pkg.
module nnu_front #(
  parameter int MAX_WIDTH = 1024,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  nnu_pkg::cfg_t                cfg,
  input  logic                         in_valid,
  input  logic                         in_command,
  input  logic [nnu_pkg::COLOR_W-1:0]  in_blue,
  input  logic [nnu_pkg::COLOR_W-1:0]  in_green,
  input  logic [nnu_pkg::COLOR_W-1:0]  in_red,
  output logic                         in_stall,
  output logic                         ram_we,
  output logic [CW-1:0]                ram_waddr,
  output logic [nnu_pkg::PIX_W-1:0]    ram_wdata,
  output logic                         ram_re,
  output logic [CW-1:0]                ram_raddr,
  input  logic [nnu_pkg::PIX_W-1:0]    ram_rdata,
  output logic                         job_valid,
  output nnu_pkg::job_t                job,
  input  logic                         job_ready
);

  nnu_pkg::phase_t phase_r, phase_nxt;
  logic [CW-1:0]                   col_r, col_nxt;
  logic [nnu_pkg::COPY_W-1:0]      copy_r, copy_nxt;
  logic [nnu_pkg::HEIGHT_W-1:0]    row_r, row_nxt;
  logic                            s1_valid_r, s1_valid_nxt;
  logic                            s1_use_ram_r;
  nnu_pkg::job_t                   s1_job_r, job_nxt;

  logic replay, take, push, end_col, last_copy, row_last, col_wrap;

  assign replay   = (phase_r == nnu_pkg::PH_REPLAY);
  assign in_stall = s1_valid_r && !job_ready;
  assign take     = in_valid && !in_stall && (in_command == replay);
  assign push     = s1_valid_r && job_ready;

  assign end_col   = (17'(col_r) + 17'd1) >= 17'(cfg.width);
  assign last_copy = replay ? ((7'(copy_r) + 7'd1) >= cfg.scale) : (cfg.scale == 7'd1);
  assign row_last  = (17'(row_r) + 17'd1) >= 17'(cfg.height);
  assign col_wrap  = (32'(col_r) == MAX_WIDTH - 1);

  // Line store: captured pixels are written, replay items read back.
  assign ram_we    = take && !replay;
  assign ram_waddr = col_r;
  assign ram_wdata = {in_red, in_green, in_blue};
  assign ram_re    = take && replay;
  assign ram_raddr = col_r;

  // Phase transitions happen only at the end of a row.
  always_comb begin
    phase_nxt = phase_r;
    if (take && end_col) begin
      phase_nxt = last_copy ? nnu_pkg::PH_CAPTURE : nnu_pkg::PH_REPLAY;
    end
  end

  always_comb begin
    col_nxt  = col_r;
    copy_nxt = copy_r;
    row_nxt  = row_r;
    if (take) begin
      if (!end_col) begin
        col_nxt = col_wrap ? '0 : col_r + CW'(1);
      end else begin
        col_nxt = '0;
        if (last_copy) begin
          copy_nxt = '0;
          row_nxt  = row_last ? '0 : row_r + 16'd1;
        end else begin
          copy_nxt = copy_r + 6'd1;
        end
      end
    end
  end

  // Job contents; the pad count is (width * scale) mod 4.
  always_comb begin
    logic [3:0] prod;
    prod            = cfg.width[1:0] * cfg.scale[1:0];
    job_nxt.blue    = in_blue;
    job_nxt.green   = in_green;
    job_nxt.red     = in_red;
    job_nxt.scale   = cfg.scale;
    job_nxt.end_col = end_col;
    job_nxt.pad     = prod[1:0];
    job_nxt.fend    = end_col && last_copy && row_last;
  end

  assign s1_valid_nxt = take ? 1'b1 : (push ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= nnu_pkg::PH_CAPTURE;
      col_r      <= '0;
      copy_r     <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      col_r      <= col_nxt;
      copy_r     <= copy_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_job_r     <= job_nxt;
      s1_use_ram_r <= replay;
    end
  end

  // A replayed pixel comes from the store's registered read port, in the cycle after the read.
  always_comb begin
    job = s1_job_r;
    if (s1_use_ram_r) begin
      job.blue  = ram_rdata[7:0];
      job.green = ram_rdata[15:8];
      job.red   = ram_rdata[23:16];
    end
  end

  assign job_valid = s1_valid_r;

endmodule

// ----- src/nnu_queue.sv -----
// Small job queue between the upscaler front end and back end.
// Depends on nnu_pkg.
module nnu_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  nnu_pkg::job_t push_job,
  output logic          ready,
  input  logic          pop,
  output logic          valid,
  output nnu_pkg::job_t head
);

  localparam int DEPTH = nnu_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);

  nnu_pkg::job_t     mem_r [DEPTH];
  logic [PW-1:0]     wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNTW-1:0]   cnt_r, cnt_nxt;

  assign ready = (32'(cnt_r) != DEPTH);
  assign valid = (cnt_r != '0);
  assign head  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (32'(wr_r) == DEPTH - 1) ? '0 : wr_r + PW'(1);
    end
    if (pop) begin
      rd_nxt = (32'(rd_r) == DEPTH - 1) ? '0 : rd_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNTW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

endmodule

// ----- src/nnu_back.sv -----
// Back end of the upscaler: sends each queued pixel out scale times through
// an output register and marks the last copy, row end, pad bytes and frame end.
// Depends on nnu_pkg.
module nnu_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  nnu_pkg::job_t                q_job,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [nnu_pkg::COLOR_W-1:0]  out_blue,
  output logic [nnu_pkg::COLOR_W-1:0]  out_green,
  output logic [nnu_pkg::COLOR_W-1:0]  out_red,
  output logic                         out_last,
  output logic                         out_row_end,
  output logic [nnu_pkg::PAD_W-1:0]    out_pad_bytes,
  output logic                         out_frame_end
);

  logic [nnu_pkg::COPY_W-1:0] k_r, k_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       load, last_beat;
  logic [nnu_pkg::COLOR_W-1:0] blue_r, green_r, red_r;
  logic                       last_r, row_end_r, frame_end_r;
  logic [nnu_pkg::PAD_W-1:0]  pad_r;

  assign load      = !out_valid_r || !out_stall;
  assign last_beat = (7'(k_r) + 7'd1) == q_job.scale;
  assign q_pop     = load && q_valid && last_beat;

  always_comb begin
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = q_valid;
      if (q_valid) begin
        k_nxt = last_beat ? '0 : k_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_valid) begin
      blue_r      <= q_job.blue;
      green_r     <= q_job.green;
      red_r       <= q_job.red;
      last_r      <= last_beat;
      row_end_r   <= last_beat && q_job.end_col;
      pad_r       <= (last_beat && q_job.end_col) ? q_job.pad : '0;
      frame_end_r <= last_beat && q_job.fend;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_blue      = blue_r;
  assign out_green     = green_r;
  assign out_red       = red_r;
  assign out_last      = last_r;
  assign out_row_end   = row_end_r;
  assign out_pad_bytes = pad_r;
  assign out_frame_end = frame_end_r;

endmodule

// ----- src/nnu_checker.sv -----
// Port-level checker for the upscaler top level, with its bind statement.
// Depends on nnu_pkg and nearest_neighbor_upscaler_core.
module nnu_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [nnu_pkg::COLOR_W-1:0] out_blue,
  input logic [nnu_pkg::COLOR_W-1:0] out_green,
  input logic [nnu_pkg::COLOR_W-1:0] out_red,
  input logic                        out_last,
  input logic                        out_row_end,
  input logic [nnu_pkg::PAD_W-1:0]   out_pad_bytes,
  input logic                        out_frame_end
);

  // A stalled output beat holds its colors and its last and row-end flags.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_blue) && $stable(out_green)
      && $stable(out_red) && $stable(out_last) && $stable(out_row_end))
    else $error("output beat changed while stalled");

  // Frame end closes a row and an item.
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_row_end && out_last)
    else $error("frame end without row end");

  // A row ends only on the last copy of a pixel.
  a_row_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_row_end |-> out_last)
    else $error("row end not on last copy");

  // Pad bytes are zero except at a row end.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_row_end |-> out_pad_bytes == '0)
    else $error("pad bytes outside row end");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind nearest_neighbor_upscaler_core nnu_checker u_nnu_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_blue      (out_blue),
  .out_green     (out_green),
  .out_red       (out_red),
  .out_last      (out_last),
  .out_row_end   (out_row_end),
  .out_pad_bytes (out_pad_bytes),
  .out_frame_end (out_frame_end)
);

// ----- test/testbench.sv -----
// Self-checking testbench for nearest_neighbor_upscaler_core. A scoreboard
// class predicts every replicated output pixel and compares it with the block.
// Depends on nnu_pkg and the upscaler RTL.
module testbench;
  import nnu_pkg::*;

  localparam int LINE_DEPTH = 1024;

  // Input command codes.
  localparam logic CMD_PIXEL  = 1'b0;
  localparam logic CMD_REPLAY = 1'b1;

  // Cycles to wait after the last expected beat, so that a stray beat that the
  // block should not send still reaches the monitor.
  localparam int SETTLE_CYCLES = 8;

  // Accepted items to send in the random part, ignored items not counted.
  localparam int RANDOM_ITEMS = 265;

  // One output beat, in the order of the block's output ports.
  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
    logic               last;
    logic               row_end;
    logic [PAD_W-1:0]   pad_bytes;
    logic               frame_end;
  } out_pixel_t;

  // The scoreboard keeps its own copy of the line store, the row position
  // and the registers, and turns each accepted item into the beats it causes.
  class upscale_scoreboard;
    logic [PIX_W-1:0] line_pixels [LINE_DEPTH];
    bit               line_written [LINE_DEPTH];
    int unsigned      column;
    int unsigned      copy_count;
    int unsigned      row;
    phase_t           phase;
    int unsigned      scale_reg;
    int unsigned      width_reg;
    int unsigned      height_reg;
    out_pixel_t       pending_pixels [$];
    int               mismatches;

    function new();
      column = 0;
      copy_count = 0;
      row = 0;
      phase = PH_CAPTURE;
      scale_reg = 1;
      width_reg = 1;
      height_reg = 1;
      mismatches = 0;
      foreach (line_written[i]) line_written[i] = 1'b0;
    endfunction

    function int unsigned eff_scale();
      if (scale_reg == 0) return 1;
      if (scale_reg > MAX_SCALE) return MAX_SCALE;
      return scale_reg;
    endfunction

    function int unsigned clamp_width(int unsigned value);
      if (value == 0) return 1;
      if (value > LINE_DEPTH) return LINE_DEPTH;
      return value;
    endfunction

    function int unsigned eff_height();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function int pending_count();
      return pending_pixels.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      case (index)
        REG_SCALE:     scale_reg = value[SCALE_W-1:0];
        REG_IN_WIDTH:  width_reg = value[WIDTH_W-1:0];
        REG_IN_HEIGHT: height_reg = value[HEIGHT_W-1:0];
        default: ;
      endcase
    endfunction

    // A wider row during a replay would read store entries never written.
    function bit width_allowed(int unsigned value);
      int unsigned limit;
      limit = clamp_width(value & 32'h7FF);
      if (phase == PH_CAPTURE) return 1'b1;
      for (int i = 0; i < limit; i++) begin
        if (!line_written[i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void replicate_pixel(logic command, logic [COLOR_W-1:0] blue,
                                  logic [COLOR_W-1:0] green, logic [COLOR_W-1:0] red);
      int unsigned      s;
      int unsigned      w;
      int unsigned      col;
      int unsigned      pad;
      logic [PIX_W-1:0] pix;
      bit               end_col;
      bit               last_copy_row;
      bit               frame_done;
      out_pixel_t       beat;
      // An item of the wrong kind for the phase is dropped without effect.
      if ((phase == PH_REPLAY) ? (command != CMD_REPLAY) : (command != CMD_PIXEL)) return;
      s = eff_scale();
      w = clamp_width(width_reg);
      col = column % LINE_DEPTH;
      if (phase == PH_CAPTURE) begin
        pix = {red, green, blue};
        line_pixels[col] = pix;
        line_written[col] = 1'b1;
        last_copy_row = (s == 1);
      end else begin
        pix = line_pixels[col];
        last_copy_row = (copy_count + 1 >= s);
      end
      // A column at or beyond the width ends the row, even after a change.
      end_col = (column + 1 >= w);
      pad = (4 - ((3 * w * s) & 3)) & 3;
      frame_done = end_col && last_copy_row && (row + 1 >= eff_height());
      for (int k = 0; k < s; k++) begin
        beat.blue = pix[7:0];
        beat.green = pix[15:8];
        beat.red = pix[23:16];
        beat.last = (k == s - 1);
        beat.row_end = beat.last && end_col;
        beat.pad_bytes = beat.row_end ? pad[PAD_W-1:0] : '0;
        beat.frame_end = beat.last && frame_done;
        pending_pixels.push_back(beat);
      end
      if (!end_col) begin
        column = (column + 1) % LINE_DEPTH;
      end else begin
        column = 0;
        if (last_copy_row) begin
          phase = PH_CAPTURE;
          copy_count = 0;
          row = (row + 1 >= eff_height()) ? 0 : ((row + 1) & 32'hFFFF);
        end else begin
          phase = PH_REPLAY;
          copy_count = (copy_count + 1) & 32'h3F;
        end
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_pixel(out_pixel_t got);
      out_pixel_t want;
      if (pending_pixels.size() == 0) begin
        $error("output beat with nothing expected: blue %0d green %0d red %0d",
               got.blue, got.green, got.red);
        mismatches++;
        return;
      end
      want = pending_pixels.pop_front();
      compare_field("out_blue", want.blue, got.blue);
      compare_field("out_green", want.green, got.green);
      compare_field("out_red", want.red, got.red);
      compare_field("out_last", 8'(want.last), 8'(got.last));
      compare_field("out_row_end", 8'(want.row_end), 8'(got.row_end));
      compare_field("out_pad_bytes", 8'(want.pad_bytes), 8'(got.pad_bytes));
      compare_field("out_frame_end", 8'(want.frame_end), 8'(got.frame_end));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_command = CMD_PIXEL;
  logic [COLOR_W-1:0]    in_blue = '0;
  logic [COLOR_W-1:0]    in_green = '0;
  logic [COLOR_W-1:0]    in_red = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [COLOR_W-1:0]    out_blue;
  logic [COLOR_W-1:0]    out_green;
  logic [COLOR_W-1:0]    out_red;
  logic                  out_last;
  logic                  out_row_end;
  logic [PAD_W-1:0]      out_pad_bytes;
  logic                  out_frame_end;

  // Idle and stall odds in percent; the main sequence changes them per segment.
  int sender_gap_pct = 0;
  int receiver_stall_pct = 0;

  upscale_scoreboard scoreboard;

  nearest_neighbor_upscaler_core #(
    .MAX_WIDTH(LINE_DEPTH)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_command(in_command),
    .in_blue(in_blue),
    .in_green(in_green),
    .in_red(in_red),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_blue(out_blue),
    .out_green(out_green),
    .out_red(out_red),
    .out_last(out_last),
    .out_row_end(out_row_end),
    .out_pad_bytes(out_pad_bytes),
    .out_frame_end(out_frame_end)
  );

  // Period of 12: high for 6, low for 6. The first edge is a rising one at 6.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The receiver decides at each falling edge whether to hold off the next beat.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Every beat taken by the receiver goes to the scoreboard. Sampling at the
  // rising edge sees the values from before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      scoreboard.check_pixel({out_blue, out_green, out_red, out_last, out_row_end,
                              out_pad_bytes, out_frame_end});
    end
  end

  // All driving tasks start and end at a falling edge.
  task automatic write_register(input logic [CFG_IDX_W-1:0] index, input int unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value[CFG_DATA_W-1:0];
    scoreboard.write_reg(index, value[CFG_DATA_W-1:0]);
    @(negedge clk);
  endtask

  task automatic configure(input int unsigned scale_value, input int unsigned width_value,
                           input int unsigned height_value);
    write_register(REG_SCALE, scale_value);
    write_register(REG_IN_WIDTH, width_value);
    write_register(REG_IN_HEIGHT, height_value);
    cfg_we <= 1'b0;
  endtask

  // Holds the sender off until every predicted beat has come out, then lets
  // the given number of further cycles pass.
  task automatic wait_for_drain(input int settle);
    in_valid <= 1'b0;
    do @(negedge clk); while (scoreboard.pending_count() != 0);
    repeat (settle) @(negedge clk);
  endtask

  // Presents one beat, with random idle cycles ahead of it, and holds it
  // steady until the block takes it.
  task automatic send_item(input logic command, input logic [COLOR_W-1:0] blue,
                           input logic [COLOR_W-1:0] green, input logic [COLOR_W-1:0] red);
    while ($urandom_range(99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= command;
    in_blue <= blue;
    in_green <= green;
    in_red <= red;
    do @(posedge clk); while (in_stall !== 1'b0);
    scoreboard.replicate_pixel(command, blue, green, red);
    @(negedge clk);
  endtask

  initial begin
    int               segment;
    int               useful;
    int               target;
    int               n;
    int               pick;
    int unsigned      scale_value;
    int unsigned      width_value;
    int unsigned      height_value;
    logic             command;
    bit               wrong;
    logic [PIX_W-1:0] color;
    scoreboard = new();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Zero registers act as one: every pixel is a whole row and a whole frame,
    // with one pad byte. A replay while capturing is dropped.
    configure(0, 0, 0);
    send_item(CMD_PIXEL, 8'h00, 8'h00, 8'h00);
    send_item(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send_item(CMD_REPLAY, 8'h5A, 8'hA5, 8'h3C);
    wait_for_drain(SETTLE_CYCLES);

    // Scale three over two columns: a captured row, then two replayed copies.
    // Items of the wrong kind in either phase are mixed in and must vanish.
    configure(3, 2, 1);
    send_item(CMD_PIXEL, 8'h12, 8'h34, 8'h56);
    send_item(CMD_REPLAY, 8'h00, 8'h00, 8'h00);
    send_item(CMD_PIXEL, 8'hAB, 8'hCD, 8'hEF);
    send_item(CMD_PIXEL, 8'h01, 8'h02, 8'h03);
    repeat (4) send_item(CMD_REPLAY, 8'hFF, 8'h00, 8'hFF);
    wait_for_drain(SETTLE_CYCLES);

    // A scale register above the limit behaves as 64. Partway through the
    // replay the scale drops to two, so the copy count already reached ends it.
    configure(127, 3, 2);
    send_item(CMD_PIXEL, 8'h80, 8'h40, 8'h20);
    send_item(CMD_PIXEL, 8'h7F, 8'hBF, 8'hDF);
    send_item(CMD_PIXEL, 8'hC3, 8'h3C, 8'h99);
    repeat (2) send_item(CMD_REPLAY, 8'h00, 8'h00, 8'h00);
    wait_for_drain(SETTLE_CYCLES);
    configure(2, 3, 2);
    send_item(CMD_REPLAY, 8'h00, 8'h00, 8'h00);
    wait_for_drain(SETTLE_CYCLES);

    // Widest setting for width and height, then both cut to one mid-row: the
    // next pixel is past the width and in the last row, so it closes both the
    // row and the frame.
    configure(1, 2047, 65535);
    send_item(CMD_PIXEL, 8'hF0, 8'h0F, 8'hAA);
    send_item(CMD_PIXEL, 8'h55, 8'hCC, 8'h33);
    wait_for_drain(SETTLE_CYCLES);
    configure(1, 1, 1);
    send_item(CMD_PIXEL, 8'hEE, 8'h11, 8'h77);

    // Random part. Each segment starts from an idle block with new register
    // values and one of four idling patterns. Mostly the right kind of item
    // for the phase, so rows and replays run to completion; a tenth are the
    // wrong kind. Segments often end mid-row, so register changes land at
    // every position of a row, a replay and a frame.
    useful = 0;
    segment = 0;
    while (useful < RANDOM_ITEMS) begin
      wait_for_drain(SETTLE_CYCLES);
      case (segment % 4)
        0: begin
          sender_gap_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_gap_pct = 56;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_gap_pct = 0;
          receiver_stall_pct = 56;
        end
        default: begin
          sender_gap_pct = 31;
          receiver_stall_pct = 31;
        end
      endcase

      pick = $urandom_range(99);
      if (pick < 65) scale_value = $urandom_range(4, 1);
      else if (pick < 75) scale_value = 0;
      else if (pick < 88) scale_value = $urandom_range(64, 5);
      else scale_value = $urandom_range(127, 65);

      pick = $urandom_range(99);
      if (pick < 60) width_value = $urandom_range(6, 1);
      else if (pick < 70) width_value = 0;
      else if (pick < 85) width_value = $urandom_range(40, 7);
      else if (pick < 93) width_value = $urandom_range(1024, 1000);
      else width_value = $urandom_range(2047, 1025);
      if (!scoreboard.width_allowed(width_value)) width_value = scoreboard.width_reg;

      pick = $urandom_range(99);
      if (pick < 60) height_value = $urandom_range(4, 1);
      else if (pick < 70) height_value = 0;
      else if (pick < 90) height_value = $urandom_range(300, 5);
      else height_value = $urandom_range(65535, 60000);

      configure(scale_value, width_value, height_value);

      // Large scales make every item cost many beats, so those segments are short.
      target = (scoreboard.eff_scale() > 8) ? $urandom_range(12, 4) : $urandom_range(40, 15);
      n = 0;
      while (n < target) begin
        // Now and then the sender waits for the block to empty completely.
        if ($urandom_range(99) < 3) wait_for_drain(0);
        wrong = ($urandom_range(99) < 10);
        command = (scoreboard.phase == PH_REPLAY) ? CMD_REPLAY : CMD_PIXEL;
        if (wrong) command = ~command;
        color = PIX_W'($urandom);
        send_item(command, color[7:0], color[15:8], color[23:16]);
        if (!wrong) n++;
      end
      useful += n;
      segment++;
    end

    // Beats that show up during the settling time are caught by the monitor.
    wait_for_drain(SETTLE_CYCLES);
    if (scoreboard.mismatches == 0 && scoreboard.pending_count() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #18_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/nnu_pkg.sv
src/nnu_ram.sv
src/nnu_front.sv
src/nnu_queue.sv
src/nnu_back.sv
src/nearest_neighbor_upscaler_core.sv
src/nnu_checker.sv
test/testbench.sv
